/* hw/rtl/rts_pkg.sv */
`timescale 1ns / 1ps
// rts_pkg: shared types and constants of the esc reverse throttle sequencer
// phase codes, pulse limits, curve coefficients and the sequencer decision struct
package rts_pkg;

  // drive phase codes
  localparam logic [1:0] PHASE_FORWARD = 2'd0;
  localparam logic [1:0] PHASE_REV_ARM = 2'd1;
  localparam logic [1:0] PHASE_REVERSE = 2'd2;
  localparam logic [1:0] PHASE_BRAKE   = 2'd3;

  // throttle pulse values, 0.1 us units
  localparam logic [14:0] NEUTRAL_PULSE = 15'd15000;
  localparam logic [14:0] FWD_MAX_PULSE = 15'd20000;
  localparam logic [14:0] REV_MIN_PULSE = 15'd10000;

  // curve terms, 0.0001 us units
  localparam logic signed [35:0] FWD_OFFSET  = 36'sd15074000;
  localparam logic signed [35:0] FWD_CAP     = 36'sd20000000;
  localparam logic signed [35:0] FWD_DEAD    = 36'sd15500000;
  localparam logic signed [35:0] REV_OFFSET  = 36'sd14730000;
  localparam logic signed [35:0] REV_FLOOR   = 36'sd10000000;
  localparam logic signed [35:0] REV_DEAD    = 36'sd14000000;
  localparam logic signed [35:0] FWD_LIN     = 36'sd200;
  localparam logic signed [35:0] REV_LIN     = 36'sd600;
  localparam logic signed [35:0] REV_QUAD    = 36'sd3;

  // x / 1000 as (x * DIV1000_RECIP) >> DIV1000_SHIFT, exact for x < 2^25
  localparam logic [25:0] DIV1000_RECIP = 26'd34359739;
  localparam int unsigned DIV1000_SHIFT = 35;

  // steering, Q20
  localparam logic signed [36:0] STEER_GAIN   = 37'sd6675442;
  localparam logic signed [39:0] STEER_CENTER = 40'sd14155776000;  // 13500 << 20
  localparam logic signed [39:0] STEER_HI_Q20 = 40'sd18811453440;  // 17940 << 20
  localparam logic signed [39:0] STEER_LO_Q20 = -40'sd9489612800;  // -9050 << 20
  localparam logic signed [15:0] STEER_HI     = 16'sd17940;
  localparam logic signed [15:0] STEER_LO     = -16'sd9050;

  // sequencer decision for the word in flight
  typedef struct packed {
    logic       use_curve;
    logic [1:0] next_phase;
  } rts_seq_t;

endpackage

/* hw/rtl/esc_reverse_throttle_sequencer.sv */
`timescale 1ns / 1ps
// esc_reverse_throttle_sequencer: top level, input register, sequencer and result register
// depends on rts_pkg, rts_throttle, rts_steer, rts_seq

// Turns one control tick (signed speed command, steering angle in milliradians)
// into one result word: ESC throttle pulse, servo steering pulse, both in 0.1 us
// units, and the drive phase after the tick. The phase register walks
// brake -> reverse arm -> reverse so the ESC sees the brake, neutral, reverse
// pattern; the throttle follows a quadratic curve, capped at 2.0 ms / 1.0 ms,
// snapped to 1.5 ms in the dead band and forced neutral where the phase says so.
// Timing: two register stages. The speed square and the steering product are
// taken at the input register, curve, clamp and sequencer sit between it and the
// result register. A word is accepted every cycle unless the input is stalled; its result
// moves from the input register into the result register once that is free; the result
// register parts the two sides, so the input register can still take a word while a
// result waits, and only a full pipeline stalls the input.
// Reset puts the drive phase into brake.
module esc_reverse_throttle_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] speed_command_i,
  input  logic signed [12:0] steer_angle_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [14:0] throttle_pulse_o,
  output logic signed [15:0] steer_pulse_o,
  output logic        [1:0]  drive_phase_o
);
  import rts_pkg::*;

  // input register stage
  logic               in_valid_q;
  logic signed [15:0] speed_q;
  logic        [31:0] speed_sq_q;
  logic signed [36:0] steer_prod_q;
  logic        [15:0] speed_mag;
  logic               in_fire;
  logic               advance;

  // result register stage
  logic               out_valid_q;
  logic        [14:0] throttle_q;
  logic signed [15:0] steer_q;
  logic        [1:0]  phase_out_q;

  logic        [14:0] curve_pulse;
  logic signed [15:0] steer_pulse;
  logic        [1:0]  phase_cur;
  rts_seq_t           seq;

  // stage moves forward when the result register is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // magnitude fits 16 unsigned bits, -32768 included
  assign speed_mag = speed_command_i[15] ? 16'(-speed_command_i) : speed_command_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      speed_q      <= speed_command_i;
      speed_sq_q   <= 32'(speed_mag) * 32'(speed_mag);
      steer_prod_q <= 37'(steer_angle_i) * STEER_GAIN;
    end
  end

  rts_throttle u_throttle (
    .speed_i       (speed_q),
    .speed_sq_i    (speed_sq_q),
    .curve_pulse_o (curve_pulse)
  );

  rts_steer u_steer (
    .steer_prod_i  (steer_prod_q),
    .steer_pulse_o (steer_pulse)
  );

  // phase register steps once per word leaving the input stage
  rts_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .spd_pos_i (speed_q > 16'sd0),
    .spd_neg_i (speed_q[15]),
    .phase_o   (phase_cur),
    .seq_o     (seq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      throttle_q  <= seq.use_curve ? curve_pulse : NEUTRAL_PULSE;
      steer_q     <= steer_pulse;
      phase_out_q <= seq.next_phase;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign throttle_pulse_o = throttle_q;
  assign steer_pulse_o    = steer_q;
  assign drive_phase_o    = phase_out_q;

  // reported phase is the phase register after the step
  a_phase_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (drive_phase_o == phase_cur))
    else $error("reported phase differs from sequencer state");

  // forward never pulls the throttle below neutral
  a_fwd_no_reverse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (drive_phase_o == PHASE_FORWARD)) |-> (throttle_pulse_o >= NEUTRAL_PULSE))
    else $error("forward phase with reverse pulse");

  // reverse and reverse arm never push the throttle above neutral
  a_rev_no_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((drive_phase_o == PHASE_REVERSE) || (drive_phase_o == PHASE_REV_ARM)))
    |-> (throttle_pulse_o <= NEUTRAL_PULSE))
    else $error("reverse phase with forward pulse");

  // pulses stay inside their clamp limits
  a_pulse_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((steer_pulse_o >= STEER_LO) && (steer_pulse_o <= STEER_HI)
                     && (throttle_pulse_o >= REV_MIN_PULSE)
                     && (throttle_pulse_o <= FWD_MAX_PULSE)))
    else $error("pulse outside clamp range");

endmodule

/* hw/rtl/rts_throttle.sv */
`timescale 1ns / 1ps
// rts_throttle: quadratic throttle curve with cap, floor and dead band
// depends on rts_pkg; takes the registered speed and its registered square
module rts_throttle (
  input  logic signed [15:0] speed_i,
  input  logic        [31:0] speed_sq_i,
  output logic        [14:0] curve_pulse_o
);
  import rts_pkg::*;

  logic signed [35:0] s_ext;
  logic signed [35:0] sq_ext;
  logic signed [35:0] fwd_t;
  logic signed [35:0] rev_u;
  logic        [24:0] div_arg;
  logic        [50:0] div_prod;
  logic        [14:0] div_q;

  assign s_ext  = 36'(speed_i);
  assign sq_ext = signed'({4'b0, speed_sq_i});

  assign fwd_t = (sq_ext <<< 1) - s_ext * FWD_LIN + FWD_OFFSET;
  assign rev_u = REV_OFFSET + s_ext * REV_LIN - sq_ext * REV_QUAD;

  // one shared divide by 1000, only used when the value is inside the curve band
  assign div_arg  = (speed_i > 16'sd0) ? fwd_t[24:0] : rev_u[24:0];
  assign div_prod = 51'(div_arg) * 51'(DIV1000_RECIP);
  assign div_q    = div_prod[DIV1000_SHIFT +: 15];

  always_comb begin
    curve_pulse_o = NEUTRAL_PULSE;
    if (speed_i > 16'sd0) begin
      if (fwd_t >= FWD_CAP) begin
        curve_pulse_o = FWD_MAX_PULSE;
      end else if (fwd_t < FWD_DEAD) begin
        curve_pulse_o = NEUTRAL_PULSE;
      end else begin
        curve_pulse_o = div_q;
      end
    end else if (speed_i < 16'sd0) begin
      if (rev_u <= REV_FLOOR) begin
        curve_pulse_o = REV_MIN_PULSE;
      end else if (rev_u > REV_DEAD) begin
        curve_pulse_o = NEUTRAL_PULSE;
      end else begin
        curve_pulse_o = div_q;
      end
    end
  end

endmodule

/* hw/rtl/rts_steer.sv */
`timescale 1ns / 1ps
// rts_steer: linear steering pulse with clamp and truncation toward zero
// depends on rts_pkg; takes the registered angle-times-gain product
module rts_steer (
  input  logic signed [36:0] steer_prod_i,
  output logic signed [15:0] steer_pulse_o
);
  import rts_pkg::*;

  logic signed [39:0] v;
  logic signed [19:0] v_floor;
  logic signed [19:0] v_trunc;

  assign v       = STEER_CENTER + 40'(steer_prod_i);
  assign v_floor = v[39:20];
  // arithmetic shift floors, so bump negatives with a fraction back toward zero
  assign v_trunc = (v[39] && (v[19:0] != 20'd0)) ? v_floor + 20'sd1 : v_floor;

  always_comb begin
    if (v >= STEER_HI_Q20) begin
      steer_pulse_o = STEER_HI;
    end else if (v <= STEER_LO_Q20) begin
      steer_pulse_o = STEER_LO;
    end else begin
      steer_pulse_o = v_trunc[15:0];
    end
  end

endmodule

/* hw/rtl/rts_seq.sv */
`timescale 1ns / 1ps
// rts_seq: forward / brake / reverse-arm / reverse drive sequencer
// depends on rts_pkg; holds the phase register, reset to brake
module rts_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               spd_pos_i,
  input  logic               spd_neg_i,
  output logic [1:0]         phase_o,
  output rts_pkg::rts_seq_t  seq_o
);
  import rts_pkg::*;

  logic [1:0] phase_q;
  logic [1:0] phase_d;
  logic       use_curve;

  always_comb begin
    phase_d   = phase_q;
    use_curve = 1'b0;
    unique case (phase_q)
      PHASE_FORWARD: begin
        use_curve = spd_pos_i;
        phase_d   = spd_pos_i ? PHASE_FORWARD : PHASE_BRAKE;
      end
      PHASE_BRAKE: begin
        use_curve = 1'b1;
        if (spd_pos_i) begin
          phase_d = PHASE_FORWARD;
        end else if (spd_neg_i) begin
          phase_d = PHASE_REV_ARM;
        end else begin
          phase_d = PHASE_BRAKE;
        end
      end
      PHASE_REV_ARM: begin
        phase_d = spd_neg_i ? PHASE_REVERSE : PHASE_BRAKE;
      end
      PHASE_REVERSE: begin
        use_curve = spd_neg_i;
        phase_d   = spd_neg_i ? PHASE_REVERSE : PHASE_BRAKE;
      end
      default: begin
        phase_d = PHASE_BRAKE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_BRAKE;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o          = phase_q;
  assign seq_o.use_curve  = use_curve;
  assign seq_o.next_phase = phase_d;

endmodule

/* tb/rts_tick_checker.sv */
`timescale 1ns / 1ps
// rts_tick_checker: watches both channels, predicts each result word and compares it
// depends on rts_pkg for the drive phase codes
module rts_tick_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] speed_command_i,
  input  logic signed [12:0] steer_angle_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic        [14:0] throttle_pulse_i,
  input  logic signed [15:0] steer_pulse_i,
  input  logic        [1:0]  drive_phase_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import rts_pkg::*;

  localparam longint ThrNeutral = 64'sd15000;
  localparam longint Q20Scale   = 64'sd1048576;
  localparam longint SteerGain  = 64'sd6675442;
  localparam longint SteerMid   = 64'sd13500 * Q20Scale;
  localparam longint SteerTop   = 64'sd17940;
  localparam longint SteerBot   = -64'sd9050;

  typedef struct packed {
    logic        [14:0] throttle;
    logic signed [15:0] steer;
    logic        [1:0]  phase;
  } tick_result_t;

  tick_result_t due_results[$];
  tick_result_t want;
  tick_result_t fresh;
  logic [1:0]   phase_q;

  // esc curve in 0.0001 us, exact in 64 bits
  function automatic logic [14:0] esc_pulse_for(input longint s);
    longint t;
    if (s > 0) begin
      t = 2 * s * s - 200 * s + 64'sd15074000;
      if (t >= 64'sd20000000) return 15'd20000;
      if (t < 64'sd15500000) return 15'(ThrNeutral);
      return 15'(t / 1000);
    end
    if (s < 0) begin
      t = -3 * s * s + 600 * s + 64'sd14730000;
      if (t <= 64'sd10000000) return 15'd10000;
      if (t > 64'sd14000000) return 15'(ThrNeutral);
      return 15'(t / 1000);
    end
    return 15'(ThrNeutral);
  endfunction

  // servo pulse in q20, division truncates toward zero
  function automatic logic signed [15:0] servo_pulse_for(input longint a);
    longint v;
    v = SteerMid + a * SteerGain;
    if (v >= SteerTop * Q20Scale) return 16'(SteerTop);
    if (v <= SteerBot * Q20Scale) return 16'(SteerBot);
    return 16'(v / Q20Scale);
  endfunction

  function automatic tick_result_t predict_tick(input longint s, input longint a,
                                                input logic [1:0] phase);
    tick_result_t r;
    r.throttle = 15'(ThrNeutral);
    r.steer    = servo_pulse_for(a);
    r.phase    = phase;
    case (phase)
      PHASE_FORWARD: begin
        if (s > 0) r.throttle = esc_pulse_for(s);
        else r.phase = PHASE_BRAKE;
      end
      PHASE_BRAKE: begin
        r.throttle = esc_pulse_for(s);
        if (s > 0) r.phase = PHASE_FORWARD;
        else if (s < 0) r.phase = PHASE_REV_ARM;
      end
      PHASE_REV_ARM: begin
        r.phase = (s < 0) ? PHASE_REVERSE : PHASE_BRAKE;
      end
      default: begin
        if (s < 0) r.throttle = esc_pulse_for(s);
        else r.phase = PHASE_BRAKE;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_BRAKE;
      due_results.delete();
      pending_o = 0;
    end else begin
      // result side first, a word never leaves in the cycle it arrives
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          $display("%0t unexpected result word: expected none actual %0d %0d %0d", $time,
                   throttle_pulse_i, $signed(steer_pulse_i), drive_phase_i);
        end else begin
          want = due_results.pop_front();
          if (throttle_pulse_i !== want.throttle) begin
            fail_count_o++;
            $display("%0t throttle_pulse mismatch: expected %0d actual %0d", $time,
                     want.throttle, throttle_pulse_i);
          end
          if (steer_pulse_i !== want.steer) begin
            fail_count_o++;
            $display("%0t steer_pulse mismatch: expected %0d actual %0d", $time,
                     $signed(want.steer), $signed(steer_pulse_i));
          end
          if (drive_phase_i !== want.phase) begin
            fail_count_o++;
            $display("%0t drive_phase mismatch: expected %0d actual %0d", $time,
                     want.phase, drive_phase_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh = predict_tick(longint'(speed_command_i), longint'(steer_angle_i), phase_q);
        due_results.push_back(fresh);
        phase_q <= fresh.phase;
      end
      pending_o = due_results.size();
    end
  end

endmodule

/* tb/esc_reverse_throttle_sequencer_test.sv */
`timescale 1ns / 1ps
// esc_reverse_throttle_sequencer_test: clock, reset, tick stimulus, receiver and verdict
// depends on esc_reverse_throttle_sequencer and rts_tick_checker
module esc_reverse_throttle_sequencer_test;

  localparam int WatchdogLimit = 2000;  // quiet cycles before giving up
  localparam int HoldCycles    = 64;    // long receiver hold-off
  localparam int DrainCycles   = 8;     // settle time after the last result
  localparam int PhaseItems    = 300;   // random words per idling phase

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] speed_cmd = '0;
  logic signed [12:0] steer_ang = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [14:0] throttle_pulse;
  logic signed [15:0] steer_pulse;
  logic        [1:0]  drive_phase;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;    // written by stimulus only
  int holds_granted = 0;  // written by the receiver only
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  esc_reverse_throttle_sequencer u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .speed_command_i (speed_cmd),
    .steer_angle_i   (steer_ang),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .throttle_pulse_o(throttle_pulse),
    .steer_pulse_o   (steer_pulse),
    .drive_phase_o   (drive_phase)
  );

  rts_tick_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .speed_command_i (speed_cmd),
    .steer_angle_i   (steer_ang),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .throttle_pulse_i(throttle_pulse),
    .steer_pulse_i   (steer_pulse),
    .drive_phase_i   (drive_phase),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[esc_reverse_throttle_sequencer] ERROR");
        $finish;
      end
    end
  end

  // result receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_granted < holds_asked) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_granted++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one tick word and return at the edge it is taken
  // valid is only lowered for an idle cycle, never between back-to-back words
  task automatic send_tick(input int s, input int a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    speed_cmd <= 16'(s);
    steer_ang <= 13'(a);
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every predicted result word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // angles: mostly full range, some around both clamp edges and the zero crossing
  function automatic int pick_angle();
    case ($urandom_range(7))
      0:       return 695 + int'($urandom_range(4));
      1:       return -3545 + int'($urandom_range(4));
      2:       return -2125 + int'($urandom_range(8));
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  // speed magnitudes weighted toward the dead band and saturation edges
  function automatic int pick_magnitude();
    case ($urandom_range(5))
      0:       return $urandom_range(1, 20);
      1:       return $urandom_range(480, 560);
      2:       return $urandom_range(560, 1800);
      3:       return $urandom_range(1, 1400);
      4:       return $urandom_range(1800, 32768);
      default: return $urandom_range(1, 32768);
    endcase
  endfunction

  function automatic int pick_forward();
    int m;
    m = pick_magnitude();
    return (m > 32767) ? 32767 : m;
  endfunction

  // one run of words shaped like real driving, or noise
  task automatic send_burst(inout int count);
    int kind;
    int n;
    kind = $urandom_range(9);
    n    = $urandom_range(1, 8);
    case (kind)
      0, 1, 2, 3: begin
        repeat (n) send_tick(pick_forward(), pick_angle());
      end
      4, 5, 6: begin
        // brake, neutral, then reverse: needs a run of negative words
        n++;
        repeat (n) send_tick(-pick_magnitude(), pick_angle());
      end
      7: begin
        n = $urandom_range(1, 3);
        repeat (n) send_tick(0, pick_angle());
      end
      default: begin
        repeat (n) send_tick(int'($urandom_range(65535)) - 32768, pick_angle());
      end
    endcase
    count += n;
  endtask

  task automatic send_random(input int target);
    int sent;
    sent = 0;
    while (sent < target) send_burst(sent);
  endtask

  // directed walk through every phase transition and saturation edge
  task automatic run_directed();
    send_tick(0, 0);             // brake holds on zero
    send_tick(32767, 4095);      // brake to forward, forward cap, steer top clamp
    send_tick(1, -4096);         // forward dead band, steer bottom clamp
    send_tick(520, 697);         // just past dead band, just under top clamp
    send_tick(1600, 698);        // upper curve, first clamped angle
    send_tick(1700, -3542);      // capped speed, just above bottom clamp
    send_tick(0, -3543);         // forward to brake with neutral pulse
    send_tick(-1, -2121);        // brake to reverse arm, steer truncates toward zero
    send_tick(-500, 1);          // reverse arm to reverse, still neutral
    send_tick(-500, -1);         // reverse curve
    send_tick(-32768, 0);        // most negative speed, floor
    send_tick(-1000, 100);
    send_tick(-1159, 200);       // last value above the floor
    send_tick(-1160, -200);      // first value on the floor
    send_tick(5, 3000);          // reverse to brake
    send_tick(-100, -3000);      // brake to reverse arm, reverse dead band
    send_tick(0, 4000);          // reverse arm back to brake on zero
    send_tick(-2, -4000);
    send_tick(300, 42);          // reverse arm back to brake on forward command
    send_tick(600, -42);         // brake to forward inside the curve
    send_tick(-5, 1234);         // forward to brake on reverse command
    send_tick(-32768, 4095);     // brake applies the floor while arming
    send_tick(-7, -1234);        // reverse, dead band near zero
    send_tick(0, 0);             // reverse to brake
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles more rarely than the receiver
    send_idle_pct = 31;
    recv_idle_pct = 45;
    run_directed();
    send_random(PhaseItems);
    wait_for_results();

    // roles swapped
    send_idle_pct = 45;
    recv_idle_pct = 31;
    send_random(PhaseItems);
    wait_for_results();

    // no idling; first a long receiver hold while words keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    send_random(40);
    send_random(PhaseItems);
    wait_for_results();

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[esc_reverse_throttle_sequencer] OK");
    end else begin
      $display("[esc_reverse_throttle_sequencer] ERROR");
    end
    $finish;
  end

endmodule
